[sv/bpos_pkg.sv]
package bpos_pkg;

    // Parameter defaults
    localparam int DEF_MAX_ORBITALS = 64;
    localparam int DEF_MAX_REACH    = 15;
    localparam int DEF_PHASE_BITS   = 16;

    // Fixed field widths
    localparam int S_W        = 32;   // overlap element, Q1.30
    localparam int TRIG_W     = 16;   // cos and sin, Q1.14
    localparam int PROD_W     = S_W + TRIG_W;
    localparam int SUM_W      = 40;   // k-space entry, Q9.30
    localparam int IDX_OUT_W  = 6;    // row and column fields of a result
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int K_W        = 16;   // k-point coordinate in turn fractions
    localparam int ROUND_SHIFT = 14;

    localparam logic [TRIG_W-1:0] TRIG_ONE = 16'd16384;
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORBITALS = 4'd0,
        REG_DIM      = 4'd1,
        REG_REACH_A  = 4'd2,
        REG_REACH_B  = 4'd3,
        REG_REACH_C  = 4'd4,
        REG_KX       = 4'd5,
        REG_KY       = 4'd6,
        REG_KZ       = 4'd7
    } t_reg_idx;

    // Sweep position status
    typedef struct packed {
        logic home;      // current cell is the home cell
        logic upper;     // current element is on or above the diagonal
        logic cell_end;  // current element is the last one of its cell
        logic fin;       // current element is the last one of the sweep
    } t_sweep_st;

    // Phase sequencer result
    typedef struct packed {
        logic                     busy;
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } t_trig;

    // Per-request control that travels down the accumulate pipeline
    typedef struct packed {
        logic                     home;
        logic                     upper;
        logic                     cell_end;
        logic                     fin;
        logic signed [TRIG_W-1:0] coef;   // cos above diagonal, -sin below
    } t_item_ctl;

    // Accumulate pipeline status
    typedef struct packed {
        logic adv;        // pipeline moves this cycle
        logic boundary;   // last element of a cell still ahead of write-back
    } t_pipe_st;

    // Quarter-wave sine, sin(i*pi/64) in Q1.14; index 32 and above is one
    function automatic logic [TRIG_W-1:0] quarter_sine(input logic [5:0] idx);
        logic [TRIG_W-1:0] v;
        case (idx)
            6'd0:  v = 16'd0;
            6'd1:  v = 16'd804;
            6'd2:  v = 16'd1606;
            6'd3:  v = 16'd2404;
            6'd4:  v = 16'd3196;
            6'd5:  v = 16'd3981;
            6'd6:  v = 16'd4756;
            6'd7:  v = 16'd5520;
            6'd8:  v = 16'd6270;
            6'd9:  v = 16'd7005;
            6'd10: v = 16'd7723;
            6'd11: v = 16'd8423;
            6'd12: v = 16'd9102;
            6'd13: v = 16'd9760;
            6'd14: v = 16'd10394;
            6'd15: v = 16'd11003;
            6'd16: v = 16'd11585;
            6'd17: v = 16'd12140;
            6'd18: v = 16'd12665;
            6'd19: v = 16'd13160;
            6'd20: v = 16'd13623;
            6'd21: v = 16'd14053;
            6'd22: v = 16'd14449;
            6'd23: v = 16'd14811;
            6'd24: v = 16'd15137;
            6'd25: v = 16'd15426;
            6'd26: v = 16'd15679;
            6'd27: v = 16'd15893;
            6'd28: v = 16'd16069;
            6'd29: v = 16'd16207;
            6'd30: v = 16'd16305;
            6'd31: v = 16'd16364;
            default: v = TRIG_ONE;
        endcase
        return v;
    endfunction

endpackage

[sv/bpos_sweep.sv]
module bpos_sweep #(
    parameter int MAX_ORBITALS = bpos_pkg::DEF_MAX_ORBITALS,
    parameter int MAX_REACH    = bpos_pkg::DEF_MAX_REACH,
    localparam int RW = (MAX_ORBITALS > 1) ? $clog2(MAX_ORBITALS) : 1,
    localparam int NW = $clog2(MAX_ORBITALS + 1),
    localparam int CW = $clog2(MAX_REACH + 1) + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_restart,
    input  logic                  i_step,
    input  logic [6:0]            i_orbitals,
    input  logic [1:0]            i_dim,
    input  logic [3:0]            i_reach_a,
    input  logic [3:0]            i_reach_b,
    input  logic [3:0]            i_reach_c,
    output logic [RW-1:0]         o_row,
    output logic [RW-1:0]         o_col,
    output logic signed [CW-1:0]  o_cell_a,
    output logic signed [CW-1:0]  o_cell_b,
    output logic signed [CW-1:0]  o_cell_c,
    output bpos_pkg::t_sweep_st   o_st
);

    typedef enum logic [1:0] {RG_HOME, RG_AXIS, RG_PLANE, RG_UPPER} t_region;

    t_region              r_region, n_region;
    logic [RW-1:0]        r_row, r_col;
    logic signed [CW-1:0] r_a, r_b, r_c, n_a, n_b, n_c;

    logic [NW-1:0]        w_side;
    logic [1:0]           w_dim;
    logic signed [CW-1:0] w_ra, w_rb, w_rc;
    logic                 w_last_col, w_last_row, w_wrap;
    logic                 w_go_plane, w_go_upper;

    function automatic logic signed [CW-1:0] clamp_reach(input logic [3:0] r);
        if (32'(r) > MAX_REACH) return CW'(MAX_REACH);
        return CW'(r);
    endfunction

    // Effective side, dimension and reaches
    always_comb begin
        if (i_orbitals == '0) begin
            w_side = NW'(1);
        end else if (32'(i_orbitals) > MAX_ORBITALS) begin
            w_side = NW'(MAX_ORBITALS);
        end else begin
            w_side = NW'(i_orbitals);
        end
        w_dim = (i_dim == 2'd0) ? 2'd1 : i_dim;
        w_ra  = clamp_reach(i_reach_a);
        w_rb  = clamp_reach(i_reach_b);
        w_rc  = clamp_reach(i_reach_c);
    end

    assign w_last_col = (32'(r_col) + 1) >= 32'(w_side);
    assign w_last_row = (32'(r_row) + 1) >= 32'(w_side);

    // Next cell of the sweep; empty regions fall through
    always_comb begin
        n_region   = r_region;
        n_a        = r_a;
        n_b        = r_b;
        n_c        = r_c;
        w_go_plane = 1'b0;
        w_go_upper = 1'b0;
        w_wrap     = 1'b0;
        case (r_region)
            RG_HOME: begin
                if (w_ra >= CW'(1)) begin
                    n_region = RG_AXIS;
                    n_a      = CW'(1);
                end else begin
                    w_go_plane = 1'b1;
                end
            end
            RG_AXIS: begin
                if (r_a < w_ra) begin
                    n_a = r_a + CW'(1);
                end else begin
                    w_go_plane = 1'b1;
                end
            end
            RG_PLANE: begin
                if (r_b < w_rb) begin
                    n_b = r_b + CW'(1);
                end else if (r_a > -w_ra) begin
                    n_a = r_a - CW'(1);
                    n_b = CW'(1);
                end else begin
                    w_go_upper = 1'b1;
                end
            end
            RG_UPPER: begin
                if (r_b > -w_rb) begin
                    n_b = r_b - CW'(1);
                end else if (r_a > -w_ra) begin
                    n_a = r_a - CW'(1);
                    n_b = w_rb;
                end else if (r_c < w_rc) begin
                    n_a = w_ra;
                    n_b = w_rb;
                    n_c = r_c + CW'(1);
                end else begin
                    w_wrap = 1'b1;
                end
            end
            default: begin
                w_wrap = 1'b1;
            end
        endcase
        if (w_go_plane) begin
            if (w_dim >= 2'd2 && w_rb >= CW'(1)) begin
                n_region = RG_PLANE;
                n_a      = w_ra;
                n_b      = CW'(1);
                n_c      = '0;
            end else begin
                w_go_upper = 1'b1;
            end
        end
        if (w_go_upper) begin
            if (w_dim == 2'd3 && w_rc >= CW'(1)) begin
                n_region = RG_UPPER;
                n_a      = w_ra;
                n_b      = w_rb;
                n_c      = CW'(1);
            end else begin
                w_wrap = 1'b1;
            end
        end
        if (w_wrap) begin
            n_region = RG_HOME;
            n_a      = '0;
            n_b      = '0;
            n_c      = '0;
        end
    end

    // Advance element, row and cell on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_row    <= '0;
            r_col    <= '0;
            r_region <= RG_HOME;
            r_a      <= '0;
            r_b      <= '0;
            r_c      <= '0;
        end else if (i_step) begin
            if (!w_last_col) begin
                r_col <= r_col + RW'(1);
            end else begin
                r_col <= '0;
                if (!w_last_row) begin
                    r_row <= r_row + RW'(1);
                end else begin
                    r_row    <= '0;
                    r_region <= n_region;
                    r_a      <= n_a;
                    r_b      <= n_b;
                    r_c      <= n_c;
                end
            end
        end
    end

    assign o_row         = r_row;
    assign o_col         = r_col;
    assign o_cell_a      = r_a;
    assign o_cell_b      = r_b;
    assign o_cell_c      = r_c;
    assign o_st.home     = (r_region == RG_HOME);
    assign o_st.upper    = (r_col >= r_row);
    assign o_st.cell_end = w_last_col && w_last_row;
    assign o_st.fin      = w_last_col && w_last_row && w_wrap;

endmodule

[sv/bpos_phase.sv]
module bpos_phase #(
    parameter int MAX_REACH  = bpos_pkg::DEF_MAX_REACH,
    parameter int PHASE_BITS = bpos_pkg::DEF_PHASE_BITS,
    localparam int CW = $clog2(MAX_REACH + 1) + 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [bpos_pkg::K_W-1:0]       i_kx,
    input  logic [bpos_pkg::K_W-1:0]       i_ky,
    input  logic [bpos_pkg::K_W-1:0]       i_kz,
    input  logic signed [CW-1:0]           i_cell_a,
    input  logic signed [CW-1:0]           i_cell_b,
    input  logic signed [CW-1:0]           i_cell_c,
    output bpos_pkg::t_trig                o_trig
);

    localparam int KW   = bpos_pkg::K_W;
    localparam int TW   = bpos_pkg::TRIG_W;
    localparam int UW   = PHASE_BITS - 1;
    localparam int FRAC = PHASE_BITS - 7;
    localparam int SHL  = (PHASE_BITS >= KW) ? PHASE_BITS - KW : 0;
    localparam int SHR  = (PHASE_BITS < KW) ? KW - PHASE_BITS : 0;
    localparam logic [UW-1:0] QUARTER = {1'b1, {(PHASE_BITS-2){1'b0}}};

    typedef enum logic [2:0] {PH_IDLE, PH_MAC, PH_UP, PH_DOWN, PH_SIGN} t_state;

    t_state                r_state;
    logic [1:0]            r_step;
    logic [KW-1:0]         r_sum;
    logic [TW-1:0]         r_up, r_down;
    logic signed [TW-1:0]  r_cos, r_sin;

    logic [KW-1:0]         w_k;
    logic signed [CW-1:0]  w_coord;
    logic [KW-1:0]         w_coord16;
    logic [KW-1:0]         w_prod;
    logic [PHASE_BITS-1:0] w_phase;
    logic [1:0]            w_quad;
    logic [UW-1:0]         w_q, w_u;
    logic [5:0]            w_idx;
    logic [FRAC-1:0]       w_frac;
    logic [TW-1:0]         w_base, w_next, w_diff, w_interp;
    logic [TW+FRAC-1:0]    w_d;

    // One k-coordinate product per step, kept modulo one turn
    always_comb begin
        case (r_step)
            2'd0: begin
                w_k     = i_kx;
                w_coord = i_cell_a;
            end
            2'd1: begin
                w_k     = i_ky;
                w_coord = i_cell_b;
            end
            default: begin
                w_k     = i_kz;
                w_coord = i_cell_c;
            end
        endcase
        w_coord16 = KW'(w_coord);
        w_prod    = w_k * w_coord16;
    end

    // Phase word, quadrant and shared interpolation of the quarter wave
    always_comb begin
        w_phase  = PHASE_BITS'((32'(r_sum) << SHL) >> SHR);
        w_quad   = w_phase[PHASE_BITS-1 -: 2];
        w_q      = {1'b0, w_phase[PHASE_BITS-3:0]};
        w_u      = (r_state == PH_UP) ? w_q : QUARTER - w_q;
        w_idx    = w_u[UW-1:FRAC];
        w_frac   = w_u[FRAC-1:0];
        w_base   = bpos_pkg::quarter_sine(w_idx);
        w_next   = bpos_pkg::quarter_sine(w_idx + 6'd1);
        w_diff   = w_next - w_base;
        w_d      = w_diff * w_frac;
        w_interp = (w_idx >= 6'd32) ? bpos_pkg::TRIG_ONE
                                    : w_base + TW'(w_d >> FRAC);
    end

    // Sequence: three multiply-adds, sine up, sine down, quadrant sign
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PH_IDLE;
            r_step  <= '0;
        end else begin
            case (r_state)
                PH_IDLE: begin
                    if (i_start) begin
                        r_state <= PH_MAC;
                        r_step  <= '0;
                    end
                end
                PH_MAC: begin
                    r_sum <= (r_step == 2'd0) ? w_prod[KW-1:0] : r_sum + w_prod[KW-1:0];
                    if (r_step == 2'd2) begin
                        r_state <= PH_UP;
                    end else begin
                        r_step <= r_step + 2'd1;
                    end
                end
                PH_UP: begin
                    r_up    <= w_interp;
                    r_state <= PH_DOWN;
                end
                PH_DOWN: begin
                    r_down  <= w_interp;
                    r_state <= PH_SIGN;
                end
                PH_SIGN: begin
                    case (w_quad)
                        2'd0: begin
                            r_sin <= $signed(r_up);
                            r_cos <= $signed(r_down);
                        end
                        2'd1: begin
                            r_sin <= $signed(r_down);
                            r_cos <= -$signed(r_up);
                        end
                        2'd2: begin
                            r_sin <= -$signed(r_up);
                            r_cos <= -$signed(r_down);
                        end
                        default: begin
                            r_sin <= -$signed(r_down);
                            r_cos <= $signed(r_up);
                        end
                    endcase
                    r_state <= PH_IDLE;
                end
                default: begin
                    r_state <= PH_IDLE;
                end
            endcase
        end
    end

    assign o_trig.busy  = (r_state != PH_IDLE);
    assign o_trig.cos_v = r_cos;
    assign o_trig.sin_v = r_sin;

endmodule

[sv/bpos_accum.sv]
module bpos_accum #(
    parameter int MAX_ORBITALS = bpos_pkg::DEF_MAX_ORBITALS,
    localparam int RW    = (MAX_ORBITALS > 1) ? $clog2(MAX_ORBITALS) : 1,
    localparam int DEPTH = MAX_ORBITALS * MAX_ORBITALS,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic [RW-1:0]                       i_row,
    input  logic [RW-1:0]                       i_col,
    input  logic signed [bpos_pkg::S_W-1:0]     i_s,
    input  bpos_pkg::t_item_ctl                 i_ctl,
    input  logic                                i_out_ready,
    output bpos_pkg::t_pipe_st                  o_st,
    output logic                                o_out_valid,
    output logic [bpos_pkg::IDX_OUT_W-1:0]      o_row,
    output logic [bpos_pkg::IDX_OUT_W-1:0]      o_col,
    output logic signed [bpos_pkg::SUM_W-1:0]   o_value,
    output logic                                o_fin
);

    localparam int SW = bpos_pkg::SUM_W;
    localparam int PW = bpos_pkg::PROD_W;

    logic signed [SW-1:0] r_mem [DEPTH];
    logic signed [SW-1:0] r_rdata;

    // Stage B: read issued, operands held
    logic                              r_b_valid;
    logic [AW-1:0]                     r_b_addr;
    logic [RW-1:0]                     r_b_row, r_b_col;
    logic signed [bpos_pkg::S_W-1:0]   r_b_s;
    bpos_pkg::t_item_ctl               r_b_ctl;

    // Stage C: product and old entry
    logic                              r_c_valid;
    logic [AW-1:0]                     r_c_addr;
    logic [RW-1:0]                     r_c_row, r_c_col;
    logic signed [bpos_pkg::S_W-1:0]   r_c_s;
    bpos_pkg::t_item_ctl               r_c_ctl;
    logic signed [PW-1:0]              r_c_prod;
    logic signed [SW-1:0]              r_c_old;

    // Output register
    logic                              r_out_valid;
    logic [RW-1:0]                     r_out_row, r_out_col;
    logic signed [SW-1:0]              r_out_value;
    logic                              r_out_fin;

    logic                              w_adv;
    logic [AW-1:0]                     w_addr;
    logic signed [PW-1:0]              w_round;
    logic signed [SW:0]                w_sum;
    logic signed [SW-1:0]              w_value;

    assign w_adv  = !r_out_valid || i_out_ready;
    assign w_addr = AW'(32'(i_row) * MAX_ORBITALS + 32'(i_col));

    // Round the product to Q.30, add, saturate; home cell overwrites
    always_comb begin
        w_round = (r_c_prod + PW'(8192)) >>> bpos_pkg::ROUND_SHIFT;
        w_sum   = (SW+1)'(r_c_old) + (SW+1)'(w_round);
        if (r_c_ctl.home) begin
            w_value = r_c_ctl.upper ? SW'(r_c_s) : '0;
        end else if (w_sum > (SW+1)'(bpos_pkg::SUM_MAX)) begin
            w_value = bpos_pkg::SUM_MAX;
        end else if (w_sum < (SW+1)'(bpos_pkg::SUM_MIN)) begin
            w_value = bpos_pkg::SUM_MIN;
        end else begin
            w_value = SW'(w_sum);
        end
    end

    // Store: one read port at accept, one write port at write-back
    always_ff @(posedge i_clk) begin
        if (i_in_valid) begin
            r_rdata <= r_mem[w_addr];
        end
        if (w_adv && r_c_valid) begin
            r_mem[r_c_addr] <= w_value;
        end
    end

    // Pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_b_valid   <= i_in_valid;
            r_c_valid   <= r_b_valid;
            r_out_valid <= r_c_valid;
        end
    end

    // Pipeline payload; hold while the output stalls
    always_ff @(posedge i_clk) begin
        if (i_in_valid) begin
            r_b_addr <= w_addr;
            r_b_row  <= i_row;
            r_b_col  <= i_col;
            r_b_s    <= i_s;
            r_b_ctl  <= i_ctl;
        end
        if (w_adv) begin
            r_c_addr    <= r_b_addr;
            r_c_row     <= r_b_row;
            r_c_col     <= r_b_col;
            r_c_s       <= r_b_s;
            r_c_ctl     <= r_b_ctl;
            r_c_prod    <= PW'($signed(r_b_ctl.coef)) * PW'(r_b_s);
            r_c_old     <= r_rdata;
            r_out_row   <= r_c_row;
            r_out_col   <= r_c_col;
            r_out_value <= w_value;
            r_out_fin   <= r_c_ctl.fin;
        end
    end

    assign o_st.adv      = w_adv;
    assign o_st.boundary = (r_b_valid && r_b_ctl.cell_end) || (r_c_valid && r_c_ctl.cell_end);
    assign o_out_valid   = r_out_valid;
    assign o_row         = bpos_pkg::IDX_OUT_W'(r_out_row);
    assign o_col         = bpos_pkg::IDX_OUT_W'(r_out_col);
    assign o_value       = r_out_value;
    assign o_fin         = r_out_fin;

endmodule

[sv/bloch_phase_overlap_sum_top.sv]
// Bloch-sum accumulator for one k-point. Overlap matrix elements (Q1.30) stream in row-major
// order, one cell after another: home cell, then the cells along the first lattice vector,
// then the rest of the home layer and the upper layers as the lattice dimension allows. Every
// element returns its updated k-space entry (Q9.30, saturating): cos*S summed on and above
// the diagonal, -sin*S below; the home cell overwrites. tlast marks the last element of the
// sweep, after which the sweep restarts at the home cell. Within a cell the block takes one
// element per cycle while the result stream is ready, set by the single read-modify-write port
// pair of the k-space memory (MAX_ORBITALS^2 x 40 bits); results pass through stages B and C
// and the output register. After the last element of each cell input pauses while the phase
// sequencer forms k.R with one shared multiplier over three steps and interpolates sine and
// cosine, which also drains the last write of the cell before the next cell reads the same
// entries. The memory needs no clearing pass: the home cell writes every entry before any
// cell reads it. Any write to the configuration port restarts the sweep at element (0,0) of
// the home cell and keeps the stored entries; write configuration only while the block is idle.
module bloch_phase_overlap_sum_top #(
    parameter int MAX_ORBITALS = bpos_pkg::DEF_MAX_ORBITALS,
    parameter int MAX_REACH    = bpos_pkg::DEF_MAX_REACH,
    parameter int PHASE_BITS   = bpos_pkg::DEF_PHASE_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bpos_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bpos_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [31:0]                        s_axis_tdata,   // [31:0] overlap_value
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [55:0]                        m_axis_tdata,   // [5:0] row, [11:6] column,
                                                               // [51:12] kspace_value, zero fill
    output logic                               m_axis_tlast    // final_res
);

    localparam int RW = (MAX_ORBITALS > 1) ? $clog2(MAX_ORBITALS) : 1;
    localparam int CW = $clog2(MAX_REACH + 1) + 1;

    logic [6:0]                       r_orbitals;
    logic [1:0]                       r_dim;
    logic [3:0]                       r_reach_a, r_reach_b, r_reach_c;
    logic [bpos_pkg::K_W-1:0]         r_kx, r_ky, r_kz;

    logic                             w_cfg_we;
    logic                             w_accept;
    logic [RW-1:0]                    w_row, w_col;
    logic signed [CW-1:0]             w_cell_a, w_cell_b, w_cell_c;
    bpos_pkg::t_sweep_st              w_sweep;
    bpos_pkg::t_trig                  w_trig;
    bpos_pkg::t_item_ctl              w_ctl;
    bpos_pkg::t_pipe_st               w_pipe;
    logic [bpos_pkg::IDX_OUT_W-1:0]   w_out_row, w_out_col;
    logic signed [bpos_pkg::SUM_W-1:0] w_out_value;
    logic                             w_out_fin;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid;

    // Configuration registers; an index beyond the list only restarts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orbitals <= 7'd1;
            r_dim      <= 2'd1;
            r_reach_a  <= '0;
            r_reach_b  <= '0;
            r_reach_c  <= '0;
            r_kx       <= '0;
            r_ky       <= '0;
            r_kz       <= '0;
        end else if (w_cfg_we) begin
            case (bpos_pkg::t_reg_idx'(i_cfg_index))
                bpos_pkg::REG_ORBITALS: r_orbitals <= i_cfg_data[6:0];
                bpos_pkg::REG_DIM:      r_dim      <= i_cfg_data[1:0];
                bpos_pkg::REG_REACH_A:  r_reach_a  <= i_cfg_data[3:0];
                bpos_pkg::REG_REACH_B:  r_reach_b  <= i_cfg_data[3:0];
                bpos_pkg::REG_REACH_C:  r_reach_c  <= i_cfg_data[3:0];
                bpos_pkg::REG_KX:       r_kx       <= i_cfg_data;
                bpos_pkg::REG_KY:       r_ky       <= i_cfg_data;
                bpos_pkg::REG_KZ:       r_kz       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Accept while the pipeline moves, trig is ready and no cell boundary is in flight
    assign s_axis_tready = w_pipe.adv && !w_trig.busy && !w_pipe.boundary;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    bpos_sweep #(
        .MAX_ORBITALS (MAX_ORBITALS),
        .MAX_REACH    (MAX_REACH)
    ) u_sweep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (w_cfg_we),
        .i_step     (w_accept),
        .i_orbitals (r_orbitals),
        .i_dim      (r_dim),
        .i_reach_a  (r_reach_a),
        .i_reach_b  (r_reach_b),
        .i_reach_c  (r_reach_c),
        .o_row      (w_row),
        .o_col      (w_col),
        .o_cell_a   (w_cell_a),
        .o_cell_b   (w_cell_b),
        .o_cell_c   (w_cell_c),
        .o_st       (w_sweep)
    );

    bpos_phase #(
        .MAX_REACH  (MAX_REACH),
        .PHASE_BITS (PHASE_BITS)
    ) u_phase (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept && w_sweep.cell_end),
        .i_kx     (r_kx),
        .i_ky     (r_ky),
        .i_kz     (r_kz),
        .i_cell_a (w_cell_a),
        .i_cell_b (w_cell_b),
        .i_cell_c (w_cell_c),
        .o_trig   (w_trig)
    );

    // Pick the coefficient for this element's triangle
    always_comb begin
        w_ctl.home     = w_sweep.home;
        w_ctl.upper    = w_sweep.upper;
        w_ctl.cell_end = w_sweep.cell_end;
        w_ctl.fin      = w_sweep.fin;
        w_ctl.coef     = w_sweep.upper ? w_trig.cos_v : -w_trig.sin_v;
    end

    bpos_accum #(
        .MAX_ORBITALS (MAX_ORBITALS)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (w_accept),
        .i_row       (w_row),
        .i_col       (w_col),
        .i_s         ($signed(s_axis_tdata)),
        .i_ctl       (w_ctl),
        .i_out_ready (m_axis_tready),
        .o_st        (w_pipe),
        .o_out_valid (m_axis_tvalid),
        .o_row       (w_out_row),
        .o_col       (w_out_col),
        .o_value     (w_out_value),
        .o_fin       (w_out_fin)
    );

    assign m_axis_tdata = {4'b0000, w_out_value, w_out_col, w_out_row};
    assign m_axis_tlast = w_out_fin;

    // The last element of a cell starts the phase sequencer for the next cell
    a_phase_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_sweep.cell_end) |=> w_trig.busy)
        else $error("phase sequencer did not start at a cell boundary");

    // The end of the sweep returns to element (0,0) of the home cell
    a_sweep_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_sweep.fin) |=> (w_sweep.home && w_row == '0 && w_col == '0))
        else $error("sweep did not wrap to the home cell");

    // A configuration write restarts the sweep
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_we |=> (w_sweep.home && w_row == '0 && w_col == '0))
        else $error("configuration write did not restart the sweep");

endmodule
